/* src/touch_drag_gesture_detector_unit_defines.svh */
// ---------------------------------------------------------------------------
// Touch drag gesture detector - assertion macros
// Shared concurrent assertion forms for the detector modules.
// ---------------------------------------------------------------------------
`ifndef TOUCH_DRAG_GESTURE_DETECTOR_UNIT_DEFINES_SVH
`define TOUCH_DRAG_GESTURE_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define TDGD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdgd assertion failed");

// next-cycle implication, off during reset
`define TDGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdgd assertion failed");

`endif

/* src/tdgd_pkg.sv */
// ---------------------------------------------------------------------------
// Touch drag gesture detector - package
// Widths, reset values, register indexes and the words passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package tdgd_pkg;

  localparam int NUM_POINTERS_DEF = 8;

  localparam int W_ID      = 3;
  localparam int W_COORD   = 12;
  localparam int W_TIME    = 32;
  localparam int W_TRAVEL  = 20;
  localparam int W_THR     = 20;
  localparam int W_OFFSET  = 13;
  localparam int W_INERTIA = 23;
  localparam int W_PROD    = W_TRAVEL + W_TIME;
  localparam int W_CFG_ADDR = 3;
  localparam int W_CFG_DATA = 20;

  localparam logic [W_COORD-1:0] BOUND_LEFT_RST   = 12'd0;
  localparam logic [W_COORD-1:0] BOUND_TOP_RST    = 12'd0;
  localparam logic [W_COORD-1:0] BOUND_RIGHT_RST  = 12'd4095;
  localparam logic [W_COORD-1:0] BOUND_BOTTOM_RST = 12'd4095;
  localparam logic [W_THR-1:0]   DRAG_THR_RST     = 20'd3000;

  typedef enum logic [W_CFG_ADDR-1:0] {
    REG_BOUND_LEFT,
    REG_BOUND_TOP,
    REG_BOUND_RIGHT,
    REG_BOUND_BOTTOM,
    REG_DRAG_THRESHOLD
  } cfg_reg_e;

  typedef logic [1:0] gest_t;
  localparam int    GEST_H_BIT = 0;
  localparam int    GEST_V_BIT = 1;
  localparam gest_t GEST_NONE  = 2'b00;
  localparam gest_t GEST_H     = 2'b01;
  localparam gest_t GEST_V     = 2'b10;

  typedef struct packed {
    logic [W_COORD-1:0] bound_left;
    logic [W_COORD-1:0] bound_top;
    logic [W_COORD-1:0] bound_right;
    logic [W_COORD-1:0] bound_bottom;
    logic [W_THR-1:0]   drag_threshold;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [W_ID-1:0]    pointer_id;
    logic [W_COORD-1:0] pos_x;
    logic [W_COORD-1:0] pos_y;
    logic               down_flag;
    logic               up_flag;
    logic [W_TIME-1:0]  time_ms;
  } in_item_t;

  typedef struct packed {
    logic                down;
    logic [W_TIME-1:0]   down_time;
    logic [W_COORD-1:0]  start_x;
    logic [W_COORD-1:0]  start_y;
    logic [W_COORD-1:0]  last_x;
    logic [W_COORD-1:0]  last_y;
    logic [W_TRAVEL-1:0] travel_x;
    logic [W_TRAVEL-1:0] travel_y;
  } ptr_entry_t;

  // word from the table update stage to the gesture stages
  typedef struct packed {
    logic [W_ID-1:0]              ev_id;
    logic [W_COORD-1:0]           ev_x;
    logic [W_COORD-1:0]           ev_y;
    logic                         ev_down;
    logic                         ev_up;
    logic                         chk;
    logic                         axis_v;
    logic                         p0_down;
    logic [W_TRAVEL-1:0]          major;
    logic [W_TIME-1:0]            held;
    logic signed [W_OFFSET-1:0]   off_x;
    logic signed [W_OFFSET-1:0]   off_y;
    logic signed [W_INERTIA-1:0]  inertia_x;
    logic signed [W_INERTIA-1:0]  inertia_y;
  } stage_t;

  typedef struct packed {
    logic [W_ID-1:0]              out_id;
    logic [W_COORD-1:0]           out_x;
    logic [W_COORD-1:0]           out_y;
    logic                         out_down;
    logic                         out_up;
    logic                         out_cancel;
    logic                         drag_h_active;
    logic                         drag_v_active;
    logic signed [W_OFFSET-1:0]   drag_offset_x;
    logic signed [W_OFFSET-1:0]   drag_offset_y;
    logic signed [W_INERTIA-1:0]  inertia_out_x;
    logic signed [W_INERTIA-1:0]  inertia_out_y;
  } out_item_t;

endpackage

`default_nettype wire

/* src/tdgd_ptr_ram.sv */
// ---------------------------------------------------------------------------
// Touch drag gesture detector - pointer table RAM
// One write and one registered read port; per-entry valid bits make
// unwritten entries read as zero after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module tdgd_ptr_ram #(
  parameter int NUM_POINTERS = tdgd_pkg::NUM_POINTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [((NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1)-1:0] rd_addr,
  output tdgd_pkg::ptr_entry_t  rd_data,
  input  logic                  wr_en,
  input  logic [((NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1)-1:0] wr_addr,
  input  tdgd_pkg::ptr_entry_t  wr_data
);

  tdgd_pkg::ptr_entry_t     mem [NUM_POINTERS];
  logic [NUM_POINTERS-1:0]  valid;
  tdgd_pkg::ptr_entry_t     rd_q;
  logic                     rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

/* src/tdgd_update.sv */
// ---------------------------------------------------------------------------
// Touch drag gesture detector - table update stage
// Read-modify-write of the pointer entry with forwarding, inertia damping
// and the pointer 0 shadow used by the gesture check.
// ---------------------------------------------------------------------------
`default_nettype none
`include "touch_drag_gesture_detector_unit_defines.svh"

module tdgd_update #(
  parameter int NUM_POINTERS = tdgd_pkg::NUM_POINTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tdgd_pkg::in_item_t    in_item,
  input  tdgd_pkg::cfg_t        cfg,
  output logic                  rd_en,
  output logic [((NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1)-1:0] rd_addr,
  input  tdgd_pkg::ptr_entry_t  rd_data,
  output logic                  wr_en,
  output logic [((NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1)-1:0] wr_addr,
  output tdgd_pkg::ptr_entry_t  wr_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output tdgd_pkg::stage_t      res
);

  localparam int AW = (NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1;
  localparam int WI = tdgd_pkg::W_INERTIA;
  localparam int WT = tdgd_pkg::W_TRAVEL;
  localparam int WC = tdgd_pkg::W_COORD;

  function automatic logic signed [WI-1:0] damp(input logic signed [WI:0] v);
    logic signed [WI+2:0] t;
    logic signed [WI:0]   q;
    begin
      t = {v[WI], v[WI], v} + {v[WI], v, 1'b0};
      q = t[WI+2:2];
      if (q[WI] != q[WI-1]) begin
        damp = q[WI] ? {1'b1, {(WI-1){1'b0}}} : {1'b0, {(WI-1){1'b1}}};
      end else begin
        damp = q[WI-1:0];
      end
    end
  endfunction

  logic                     s1_v;
  tdgd_pkg::in_item_t       itm;
  logic                     fwd_hit;
  tdgd_pkg::ptr_entry_t     fwd_data;
  logic signed [WI-1:0]     inertia_x, inertia_y;
  logic signed [WI-1:0]     inertia_x_next, inertia_y_next;
  tdgd_pkg::ptr_entry_t     p0, p0_next;

  tdgd_pkg::ptr_entry_t     cur, nxt;
  logic                     leave, we, id_ok, in_id_ok, in_area, is_p0;
  logic signed [WC:0]       dx, dy;
  logic [WC-1:0]            adx, ady;
  logic [WT:0]              tx_sum, ty_sum;

  assign in_ready  = !s1_v || res_ready;
  assign leave     = s1_v && res_ready;
  assign in_id_ok  = int'(in_item.pointer_id) < NUM_POINTERS;
  assign rd_en     = in_ready;
  assign rd_addr   = in_id_ok ? AW'(in_item.pointer_id) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      fwd_hit   <= 1'b0;
      inertia_x <= '0;
      inertia_y <= '0;
      p0        <= '0;
    end else begin
      if (in_ready) begin
        s1_v    <= in_valid;
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
      if (leave) begin
        inertia_x <= inertia_x_next;
        inertia_y <= inertia_y_next;
        p0        <= p0_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      itm      <= in_item;
      fwd_data <= wr_data;
    end
  end

  assign cur     = fwd_hit ? fwd_data : rd_data;
  assign id_ok   = int'(itm.pointer_id) < NUM_POINTERS;
  assign in_area = (itm.pos_x >= cfg.bound_left) && (itm.pos_x < cfg.bound_right) &&
                   (itm.pos_y >= cfg.bound_top)  && (itm.pos_y < cfg.bound_bottom);

  assign dx  = $signed({1'b0, itm.pos_x}) - $signed({1'b0, cur.last_x});
  assign dy  = $signed({1'b0, itm.pos_y}) - $signed({1'b0, cur.last_y});
  assign adx = dx[WC] ? WC'(-dx) : dx[WC-1:0];
  assign ady = dy[WC] ? WC'(-dy) : dy[WC-1:0];
  assign tx_sum = {1'b0, cur.travel_x} + (WT+1)'(adx);
  assign ty_sum = {1'b0, cur.travel_y} + (WT+1)'(ady);

  always_comb begin
    nxt            = cur;
    we             = 1'b0;
    inertia_x_next = inertia_x;
    inertia_y_next = inertia_y;
    if (itm.req_type) begin
      inertia_x_next = damp({inertia_x[WI-1], inertia_x});
      inertia_y_next = damp({inertia_y[WI-1], inertia_y});
    end else if (id_ok) begin
      we = 1'b1;
      priority if (itm.down_flag && in_area) begin
        nxt.down       = 1'b1;
        nxt.down_time  = itm.time_ms;
        nxt.start_x    = itm.pos_x;
        nxt.start_y    = itm.pos_y;
        nxt.last_x     = itm.pos_x;
        nxt.last_y     = itm.pos_y;
        nxt.travel_x   = '0;
        nxt.travel_y   = '0;
        inertia_x_next = '0;
        inertia_y_next = '0;
      end else if (itm.up_flag) begin
        nxt.down = 1'b0;
      end else begin
        nxt.travel_x   = tx_sum[WT] ? '1 : tx_sum[WT-1:0];
        nxt.travel_y   = ty_sum[WT] ? '1 : ty_sum[WT-1:0];
        inertia_x_next = damp({inertia_x[WI-1], inertia_x} +
                              {{3{dx[WC]}}, dx, 8'b0});
        inertia_y_next = damp({inertia_y[WI-1], inertia_y} +
                              {{3{dy[WC]}}, dy, 8'b0});
        nxt.last_x     = itm.pos_x;
        nxt.last_y     = itm.pos_y;
      end
    end
  end

  assign is_p0   = !itm.req_type && (itm.pointer_id == '0);
  assign p0_next = (we && is_p0) ? nxt : p0;

  assign wr_en   = leave && we;
  assign wr_addr = AW'(itm.pointer_id);
  assign wr_data = nxt;

  always_comb begin
    res           = '0;
    if (!itm.req_type) begin
      res.ev_id   = itm.pointer_id;
      res.ev_x    = itm.pos_x;
      res.ev_y    = itm.pos_y;
      res.ev_down = itm.down_flag;
      res.ev_up   = itm.up_flag;
    end
    res.chk       = is_p0 && (p0_next.travel_x != p0_next.travel_y);
    res.axis_v    = p0_next.travel_y > p0_next.travel_x;
    res.p0_down   = p0_next.down;
    res.major     = res.axis_v ? p0_next.travel_y : p0_next.travel_x;
    res.held      = itm.time_ms - p0_next.down_time;
    res.off_x     = $signed({1'b0, p0_next.last_x}) - $signed({1'b0, p0_next.start_x});
    res.off_y     = $signed({1'b0, p0_next.last_y}) - $signed({1'b0, p0_next.start_y});
    res.inertia_x = inertia_x_next;
    res.inertia_y = inertia_y_next;
  end

  assign res_valid = s1_v;

  `TDGD_ASSERT_NEXT(a_s1_hold, clk, rst, s1_v && !res_ready, s1_v && $stable(itm))

endmodule

`default_nettype wire

/* src/tdgd_gesture.sv */
// ---------------------------------------------------------------------------
// Touch drag gesture detector - gesture stages
// Held-time product, threshold test, active gesture state and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "touch_drag_gesture_detector_unit_defines.svh"

module tdgd_gesture (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tdgd_pkg::stage_t                    in_word,
  input  logic [tdgd_pkg::W_THR-1:0]          thr,
  output logic                                m_valid,
  input  logic                                m_ready,
  output tdgd_pkg::out_item_t                 m_word
);

  localparam int WP = tdgd_pkg::W_PROD;

  logic                  s2_v, s3_v;
  tdgd_pkg::stage_t      s2, s3;
  logic [WP-1:0]         s3_prod;
  tdgd_pkg::gest_t       ag, ag_next;
  tdgd_pkg::out_item_t   out_q, out_next;
  logic                  en2, en3, en_out, start, h, v;

  assign en_out   = !m_valid || m_ready;
  assign en3      = !s3_v || en_out;
  assign en2      = !s2_v || en3;
  assign in_ready = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      m_valid <= 1'b0;
      ag      <= tdgd_pkg::GEST_NONE;
    end else begin
      if (en2) begin
        s2_v <= in_valid;
      end
      if (en3) begin
        s3_v <= s2_v;
      end
      if (en_out) begin
        m_valid <= s3_v;
      end
      if (en_out && s3_v) begin
        ag <= ag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2 <= in_word;
    end
    if (en3) begin
      s3      <= s2;
      s3_prod <= WP'(s2.major) * WP'(s2.held);
    end
    if (en_out) begin
      out_q <= out_next;
    end
  end

  assign start = s3.chk && s3.p0_down && (ag == tdgd_pkg::GEST_NONE) &&
                 (s3_prod > WP'(thr));

  always_comb begin
    ag_next = ag;
    if (s3.chk) begin
      if (!s3.p0_down) begin
        ag_next = tdgd_pkg::GEST_NONE;
      end else if (start) begin
        ag_next = s3.axis_v ? tdgd_pkg::GEST_V : tdgd_pkg::GEST_H;
      end
    end
  end

  assign h = ag_next[tdgd_pkg::GEST_H_BIT];
  assign v = ag_next[tdgd_pkg::GEST_V_BIT];

  always_comb begin
    out_next.out_id        = s3.ev_id;
    out_next.out_x         = s3.ev_x;
    out_next.out_y         = s3.ev_y;
    out_next.out_down      = start ? 1'b0 : s3.ev_down;
    out_next.out_up        = start ? 1'b1 : s3.ev_up;
    out_next.out_cancel    = start;
    out_next.drag_h_active = h;
    out_next.drag_v_active = v;
    out_next.drag_offset_x = h ? s3.off_x : '0;
    out_next.drag_offset_y = v ? s3.off_y : '0;
    out_next.inertia_out_x = h ? s3.inertia_x : '0;
    out_next.inertia_out_y = v ? s3.inertia_y : '0;
  end

  assign m_word = out_q;

  `TDGD_ASSERT_IMPL(a_gest_single, clk, rst, 1'b1, $onehot0(ag))
  `TDGD_ASSERT_IMPL(a_out_flags, clk, rst, m_valid,
                    ag == {out_q.drag_v_active, out_q.drag_h_active})
  `TDGD_ASSERT_NEXT(a_no_axis_swap, clk, rst, s3_v && en_out && (ag != tdgd_pkg::GEST_NONE),
                    (ag == $past(ag)) || (ag == tdgd_pkg::GEST_NONE))

endmodule

`default_nettype wire

/* src/touch_drag_gesture_detector_unit.sv */
// ---------------------------------------------------------------------------
// Touch drag gesture detector
// Pointer table in RAM, inertia damping and pointer 0 drag detection.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid / s_tready  s_tdata event, s_tuser request kind
//   m_*       out  m_tvalid / m_tready  m_tdata result
//   cfg_*     in   cfg_we               cfg_addr, cfg_data
//
// One word per clock sustained while m_tready stays high; a taken word passes
// the table read and update, a second register, the product and the output
// register before it appears at m_*. The update stage gives back-to-back
// updates of one pointer through a forwarding register.
// Reset clears the table at once through per-entry valid bits.
// With m_tready low the output register holds and the four stages fill
// before s_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_drag_gesture_detector_unit #(
  parameter int NUM_POINTERS = tdgd_pkg::NUM_POINTERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // pointer_id, pos_x, pos_y, down_flag, up_flag, time_ms, zero fill
  input  logic [63:0]                          s_tdata,
  // req_type
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_id, out_x, out_y, out_down, out_up, out_cancel, drag_h_active,
  // drag_v_active, drag_offset_x, drag_offset_y, inertia_out_x, inertia_out_y
  output logic [103:0]                         m_tdata,
  input  logic                                 cfg_we,
  input  logic [tdgd_pkg::W_CFG_ADDR-1:0]      cfg_addr,
  input  logic [tdgd_pkg::W_CFG_DATA-1:0]      cfg_data
);

  localparam int AW = (NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1;

  tdgd_pkg::cfg_t         cfg;
  tdgd_pkg::in_item_t     in_item;
  tdgd_pkg::ptr_entry_t   rd_data, wr_data;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  tdgd_pkg::stage_t       s1_word;
  logic                   s1_valid, s1_ready;
  tdgd_pkg::out_item_t    m_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bound_left     <= tdgd_pkg::BOUND_LEFT_RST;
      cfg.bound_top      <= tdgd_pkg::BOUND_TOP_RST;
      cfg.bound_right    <= tdgd_pkg::BOUND_RIGHT_RST;
      cfg.bound_bottom   <= tdgd_pkg::BOUND_BOTTOM_RST;
      cfg.drag_threshold <= tdgd_pkg::DRAG_THR_RST;
    end else if (cfg_we) begin
      unique case (tdgd_pkg::cfg_reg_e'(cfg_addr))
        tdgd_pkg::REG_BOUND_LEFT: begin
          cfg.bound_left <= cfg_data[tdgd_pkg::W_COORD-1:0];
        end
        tdgd_pkg::REG_BOUND_TOP: begin
          cfg.bound_top <= cfg_data[tdgd_pkg::W_COORD-1:0];
        end
        tdgd_pkg::REG_BOUND_RIGHT: begin
          cfg.bound_right <= cfg_data[tdgd_pkg::W_COORD-1:0];
        end
        tdgd_pkg::REG_BOUND_BOTTOM: begin
          cfg.bound_bottom <= cfg_data[tdgd_pkg::W_COORD-1:0];
        end
        tdgd_pkg::REG_DRAG_THRESHOLD: begin
          cfg.drag_threshold <= cfg_data[tdgd_pkg::W_THR-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_item.req_type   = s_tuser;
  assign in_item.pointer_id = s_tdata[2:0];
  assign in_item.pos_x      = s_tdata[14:3];
  assign in_item.pos_y      = s_tdata[26:15];
  assign in_item.down_flag  = s_tdata[27];
  assign in_item.up_flag    = s_tdata[28];
  assign in_item.time_ms    = s_tdata[60:29];

  tdgd_ptr_ram #(
    .NUM_POINTERS (NUM_POINTERS)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tdgd_update #(
    .NUM_POINTERS (NUM_POINTERS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .cfg       (cfg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (s1_valid),
    .res_ready (s1_ready),
    .res       (s1_word)
  );

  tdgd_gesture u_gesture (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_ready (s1_ready),
    .in_word  (s1_word),
    .thr      (cfg.drag_threshold),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_word   (m_word)
  );

  assign m_tdata = {m_word.inertia_out_y,
                    m_word.inertia_out_x,
                    m_word.drag_offset_y,
                    m_word.drag_offset_x,
                    m_word.drag_v_active,
                    m_word.drag_h_active,
                    m_word.out_cancel,
                    m_word.out_up,
                    m_word.out_down,
                    m_word.out_y,
                    m_word.out_x,
                    m_word.out_id};

endmodule

`default_nettype wire

/* test/touch_drag_gesture_detector_unit_tb.sv */
// ---------------------------------------------------------------------------
// Touch drag gesture detector - testbench
// Streams touch events and frame ticks through the detector with random
// gaps and back-pressure. A scoreboard class predicts every result word
// from its own copy of the pointer table, inertia and gesture state.
// The run covers directed corner cases, then random drag and multi-touch
// sequences under several bound and threshold settings.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_drag_gesture_detector_unit_tb;
  import tdgd_pkg::*;

  localparam int     NPTR        = NUM_POINTERS_DEF;
  localparam int     COORD_MAX   = (1 << W_COORD) - 1;
  localparam longint TRAVEL_SAT  = (longint'(1) << W_TRAVEL) - 1;
  localparam longint INERTIA_HI  = (longint'(1) << (W_INERTIA - 1)) - 1;
  localparam longint INERTIA_LO  = -(longint'(1) << (W_INERTIA - 1));
  localparam int     IDLE_LIMIT  = 4000;

  class gesture_predictor;
    logic [W_COORD-1:0]  bnd_left, bnd_top, bnd_right, bnd_bottom;
    logic [W_THR-1:0]    drag_thr;
    bit                  ptr_dn[NPTR];
    logic [W_TIME-1:0]   dn_time[NPTR];
    logic [W_COORD-1:0]  start_x[NPTR], start_y[NPTR], last_x[NPTR], last_y[NPTR];
    logic [W_TRAVEL-1:0] travel_x[NPTR], travel_y[NPTR];
    longint              inertia_x, inertia_y;
    gest_t               active;
    out_item_t           expected_results[$];
    int                  errors;

    function new();
      bnd_left   = BOUND_LEFT_RST;
      bnd_top    = BOUND_TOP_RST;
      bnd_right  = BOUND_RIGHT_RST;
      bnd_bottom = BOUND_BOTTOM_RST;
      drag_thr   = DRAG_THR_RST;
      for (int i = 0; i < NPTR; i++) begin
        ptr_dn[i]   = 0;
        dn_time[i]  = '0;
        start_x[i]  = '0;
        start_y[i]  = '0;
        last_x[i]   = '0;
        last_y[i]   = '0;
        travel_x[i] = '0;
        travel_y[i] = '0;
      end
      inertia_x = 0;
      inertia_y = 0;
      active    = GEST_NONE;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [W_CFG_DATA-1:0] v);
      case (idx)
        REG_BOUND_LEFT:     bnd_left   = v[W_COORD-1:0];
        REG_BOUND_TOP:      bnd_top    = v[W_COORD-1:0];
        REG_BOUND_RIGHT:    bnd_right  = v[W_COORD-1:0];
        REG_BOUND_BOTTOM:   bnd_bottom = v[W_COORD-1:0];
        REG_DRAG_THRESHOLD: drag_thr   = v[W_THR-1:0];
        default: ;
      endcase
    endfunction

    // x 3/4 with floor, saturated to the inertia width
    function longint damp(longint v);
      longint r;
      r = (v * 3) >>> 2;
      if (r > INERTIA_HI) r = INERTIA_HI;
      if (r < INERTIA_LO) r = INERTIA_LO;
      return r;
    endfunction

    function logic [W_TRAVEL-1:0] travel_add(logic [W_TRAVEL-1:0] t, int d);
      longint s;
      s = longint'(t) + longint'((d < 0) ? -d : d);
      return (s > TRAVEL_SAT) ? TRAVEL_SAT[W_TRAVEL-1:0] : s[W_TRAVEL-1:0];
    endfunction

    function bit axis_check(longint major, longint minor, gest_t axis, logic [W_TIME-1:0] now);
      logic [W_TIME-1:0] held32;
      longint held;
      if (major <= minor) return 0;
      if (ptr_dn[0]) begin
        held32 = now - dn_time[0];
        held = longint'(held32);
        if (active == GEST_NONE && major * held > longint'(drag_thr)) begin
          active = active | axis;
          return 1;
        end
      end else begin
        active = GEST_NONE;
      end
      return 0;
    endfunction

    function void note_event(in_item_t it);
      out_item_t r;
      int dx, dy, id;
      bit in_area, cancel;
      r = '0;
      cancel = 0;
      if (it.req_type) begin
        inertia_x = damp(inertia_x);
        inertia_y = damp(inertia_y);
      end else begin
        id = int'(it.pointer_id);
        r.out_id   = it.pointer_id;
        r.out_x    = it.pos_x;
        r.out_y    = it.pos_y;
        r.out_down = it.down_flag;
        r.out_up   = it.up_flag;
        in_area = it.pos_x >= bnd_left && it.pos_x < bnd_right &&
                  it.pos_y >= bnd_top && it.pos_y < bnd_bottom;
        if (it.down_flag && in_area) begin
          ptr_dn[id]   = 1;
          dn_time[id]  = it.time_ms;
          start_x[id]  = it.pos_x;
          start_y[id]  = it.pos_y;
          last_x[id]   = it.pos_x;
          last_y[id]   = it.pos_y;
          travel_x[id] = '0;
          travel_y[id] = '0;
          inertia_x = 0;
          inertia_y = 0;
        end else if (it.up_flag) begin
          ptr_dn[id] = 0;
        end else begin
          dx = int'(it.pos_x) - int'(last_x[id]);
          dy = int'(it.pos_y) - int'(last_y[id]);
          travel_x[id] = travel_add(travel_x[id], dx);
          travel_y[id] = travel_add(travel_y[id], dy);
          inertia_x = damp(inertia_x + longint'(dx) * 256);
          inertia_y = damp(inertia_y + longint'(dy) * 256);
          last_x[id] = it.pos_x;
          last_y[id] = it.pos_y;
        end
        if (id == 0) begin
          cancel = axis_check(travel_y[0], travel_x[0], GEST_V, it.time_ms);
          if (!cancel) cancel = axis_check(travel_x[0], travel_y[0], GEST_H, it.time_ms);
          if (cancel) begin
            r.out_down   = 0;
            r.out_up     = 1;
            r.out_cancel = 1;
          end
        end
      end
      r.drag_h_active = active[GEST_H_BIT];
      r.drag_v_active = active[GEST_V_BIT];
      if (r.drag_h_active) begin
        r.drag_offset_x = W_OFFSET'(int'(last_x[0]) - int'(start_x[0]));
        r.inertia_out_x = W_INERTIA'(inertia_x);
      end
      if (r.drag_v_active) begin
        r.drag_offset_y = W_OFFSET'(int'(last_y[0]) - int'(start_y[0]));
        r.inertia_out_y = W_INERTIA'(inertia_y);
      end
      expected_results.push_back(r);
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t  %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [103:0] w);
      out_item_t got, want;
      got.out_id        = w[2:0];
      got.out_x         = w[14:3];
      got.out_y         = w[26:15];
      got.out_down      = w[27];
      got.out_up        = w[28];
      got.out_cancel    = w[29];
      got.drag_h_active = w[30];
      got.drag_v_active = w[31];
      got.drag_offset_x = w[44:32];
      got.drag_offset_y = w[57:45];
      got.inertia_out_x = w[80:58];
      got.inertia_out_y = w[103:81];
      if (expected_results.size() == 0) begin
        $display("%0t  result word %h with nothing expected", $time, w);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("out_id", want.out_id, got.out_id);
      compare("out_x", want.out_x, got.out_x);
      compare("out_y", want.out_y, got.out_y);
      compare("out_down", want.out_down, got.out_down);
      compare("out_up", want.out_up, got.out_up);
      compare("out_cancel", want.out_cancel, got.out_cancel);
      compare("drag_h_active", want.drag_h_active, got.drag_h_active);
      compare("drag_v_active", want.drag_v_active, got.drag_v_active);
      compare("drag_offset_x", want.drag_offset_x, got.drag_offset_x);
      compare("drag_offset_y", want.drag_offset_y, got.drag_offset_y);
      compare("inertia_out_x", want.inertia_out_x, got.inertia_out_x);
      compare("inertia_out_y", want.inertia_out_y, got.inertia_out_y);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [103:0]          m_tdata;
  logic                  cfg_we = 1'b0;
  logic [W_CFG_ADDR-1:0] cfg_addr = '0;
  logic [W_CFG_DATA-1:0] cfg_data = '0;

  gesture_predictor model;
  logic [W_TIME-1:0] now_ms = '0;
  int  items_sent = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  tx_calm = 0;
  bit  rx_calm = 0;
  int  area_l = int'(BOUND_LEFT_RST);
  int  area_t = int'(BOUND_TOP_RST);
  int  area_r = int'(BOUND_RIGHT_RST);
  int  area_b = int'(BOUND_BOTTOM_RST);

  touch_drag_gesture_detector_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic int inside_x();
    if (area_l < area_r) return $urandom_range(area_l, area_r - 1);
    return $urandom_range(0, COORD_MAX);
  endfunction

  function automatic int inside_y();
    if (area_t < area_b) return $urandom_range(area_t, area_b - 1);
    return $urandom_range(0, COORD_MAX);
  endfunction

  function automatic int outside_x();
    if (area_l > 0 && $urandom_range(0, 1)) return $urandom_range(0, area_l - 1);
    return $urandom_range(area_r, COORD_MAX);
  endfunction

  // result side: random back-pressure, every accepted word checked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) model.check_word(m_tdata);
      if (stall_left == 0 && !rx_calm) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic put_word(in_item_t it);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= it.req_type;
    s_tdata  <= {3'b000, it.time_ms, it.up_flag, it.down_flag, it.pos_y, it.pos_x,
                 it.pointer_id};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    model.note_event(it);
    items_sent++;
  endtask

  task automatic send_touch(int id, int x, int y, bit dn, bit up);
    in_item_t it;
    it.req_type   = 1'b0;
    it.pointer_id = W_ID'(id);
    it.pos_x      = W_COORD'(x);
    it.pos_y      = W_COORD'(y);
    it.down_flag  = dn;
    it.up_flag    = up;
    it.time_ms    = now_ms;
    put_word(it);
  endtask

  // frame tick; the event fields carry random junk
  task automatic send_tick();
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom(), $urandom()};
    it = raw[61:0];
    it.req_type = 1'b1;
    put_word(it);
  endtask

  task automatic noise_item();
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom(), $urandom()};
    it = raw[61:0];
    put_word(it);
  endtask

  // hold off until every result is back
  task automatic settle_outputs();
    s_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int v);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= W_CFG_DATA'(v);
    @(posedge clk);
    model.set_reg(idx, W_CFG_DATA'(v));
  endtask

  task automatic configure(int l, int t, int r, int b, int thr);
    settle_outputs();
    write_reg(REG_BOUND_LEFT, l);
    write_reg(REG_BOUND_TOP, t);
    write_reg(REG_BOUND_RIGHT, r);
    write_reg(REG_BOUND_BOTTOM, b);
    write_reg(REG_DRAG_THRESHOLD, thr);
    cfg_we <= 1'b0;
    area_l = l;
    area_t = t;
    area_r = r;
    area_b = b;
  endtask

  task automatic directed_cases();
    in_item_t it;
    send_tick();
    now_ms = 32'hFFFF_FFF0;
    send_touch(0, 0, 0, 1, 0);
    now_ms = 32'hFFFF_FFFF;
    send_touch(0, 0, 40, 0, 0);
    // held time wraps through zero; vertical drag starts here
    now_ms = 32'h0000_0010;
    send_touch(0, 0, 200, 0, 0);
    now_ms = 32'h0000_0020;
    send_touch(0, 10, 300, 0, 0);
    send_tick();
    send_touch(0, 10, 300, 0, 1);
    now_ms = 1000;
    send_touch(0, COORD_MAX - 1, COORD_MAX - 1, 1, 0);
    now_ms = 1100;
    send_touch(0, 3000, COORD_MAX - 1, 0, 0);
    send_touch(0, COORD_MAX, COORD_MAX, 0, 0);
    // down outside the area falls through to up
    send_touch(0, COORD_MAX, COORD_MAX, 1, 1);
    send_touch(1, COORD_MAX, 0, 1, 0);
    send_touch(1, COORD_MAX, 0, 0, 1);
    now_ms = 0;
    send_touch(NPTR - 1, 2048, 2048, 1, 1);
    send_touch(NPTR - 1, 2048, 2048, 0, 0);
    // equal travel on both axes
    now_ms = 5000;
    send_touch(0, 100, 100, 1, 0);
    now_ms = 5100;
    send_touch(0, 150, 150, 0, 0);
    send_touch(0, 50, 50, 0, 0);
    send_tick();
    send_tick();
    send_touch(0, 50, 50, 0, 1);
    send_touch(0, 70, 20, 0, 0);
    it = '1;
    put_word(it);
  endtask

  // pointer 0 swept between the corners until travel saturates
  task automatic shake_pointer0();
    now_ms += 100;
    send_touch(0, 0, 0, 1, 0);
    for (int k = 0; k < 260; k++) begin
      now_ms += 1;
      send_touch(0, (k % 2 == 0) ? COORD_MAX : 0, (k % 2 == 0) ? COORD_MAX : 0, 0, 0);
    end
    send_touch(0, 0, 0, 0, 1);
  endtask

  task automatic drag_sequence();
    int x, y, n, major, minor, sx, sy;
    bit vert;
    x = inside_x();
    y = inside_y();
    vert = $urandom_range(0, 1);
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    now_ms += $urandom_range(1, 1000);
    send_touch(0, x, y, 1, $urandom_range(0, 9) == 0);
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      major = $urandom_range(0, 300);
      minor = $urandom_range(0, major / 2 + 1);
      if (vert) begin
        y = clamp_coord(y + sy * major);
        x = clamp_coord(x + sx * minor);
      end else begin
        x = clamp_coord(x + sx * major);
        y = clamp_coord(y + sy * minor);
      end
      now_ms += $urandom_range(0, 60);
      if ($urandom_range(0, 5) == 0) send_tick();
      send_touch(0, x, y, 0, 0);
    end
    if ($urandom_range(0, 4) != 0) begin
      now_ms += $urandom_range(0, 60);
      send_touch(0, x, y, $urandom_range(0, 3) == 0, 1);
    end
  endtask

  task automatic multi_sequence();
    int id, x, y, n, d;
    id = $urandom_range(1, NPTR - 1);
    x = inside_x();
    y = inside_y();
    now_ms += $urandom_range(1, 500);
    send_touch(id, x, y, 1, 0);
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      d = $urandom_range(0, 400);
      x = clamp_coord(x + d - 200);
      d = $urandom_range(0, 400);
      y = clamp_coord(y + d - 200);
      now_ms += $urandom_range(0, 40);
      if ($urandom_range(0, 3) == 0) send_touch(0, inside_x(), inside_y(), 0, 0);
      send_touch(id, x, y, 0, 0);
    end
    send_touch(id, x, y, 0, 1);
  endtask

  task automatic broken_sequence();
    int id;
    id = $urandom_range(0, NPTR - 1);
    case ($urandom_range(0, 3))
      0: send_touch(id, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 0, 0);
      1: send_touch(id, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 0, 1);
      2: send_touch(id, outside_x(), $urandom_range(0, COORD_MAX), 1, 0);
      default: begin
        send_touch(0, inside_x(), inside_y(), 1, 0);
        now_ms += $urandom_range(0, 200);
        send_touch(0, inside_x(), inside_y(), 1, 0);
      end
    endcase
  endtask

  task automatic random_phase(int target);
    int pick;
    while (items_sent < target) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) now_ms = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 45) drag_sequence();
      else if (pick < 60) multi_sequence();
      else if (pick < 72) repeat ($urandom_range(1, 5)) send_tick();
      else if (pick < 85) noise_item();
      else if (pick < 97) broken_sequence();
      else settle_outputs();
    end
  endtask

  initial begin
    int l, t;
    model = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed_cases();
    shake_pointer0();
    random_phase(520);

    configure(0, 0, COORD_MAX, COORD_MAX, 0);
    random_phase(780);

    configure(100, 200, 3000, 3500, 1000000);
    random_phase(1080);

    // empty touch area: no down ever starts a pointer
    configure(COORD_MAX, COORD_MAX, 0, 0, int'(DRAG_THR_RST));
    random_phase(1230);

    l = $urandom_range(0, 2000);
    t = $urandom_range(0, 2000);
    configure(l, t, $urandom_range(l + 1, COORD_MAX), $urandom_range(t + 1, COORD_MAX),
              $urandom_range(0, 1000000));
    random_phase(1530);

    configure(0, 0, COORD_MAX, COORD_MAX, $urandom_range(1, 5000));
    random_phase(1870);

    settle_outputs();
    if (model.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* touch_drag_gesture_detector_unit.f */
+incdir+src
src/tdgd_pkg.sv
src/tdgd_ptr_ram.sv
src/tdgd_update.sv
src/tdgd_gesture.sv
src/touch_drag_gesture_detector_unit.sv
test/touch_drag_gesture_detector_unit_tb.sv
